// ----- design/fbpa_pkg.sv -----
// Shared types and constants for the fixed block pool allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package fbpa_pkg;

    // Field widths
    localparam int FBPA_ADDR_W    = 32;
    localparam int FBPA_UNIT_W    = 16;
    localparam int FBPA_COUNT_W   = 17;
    localparam int FBPA_CMD_W     = 2;
    localparam int FBPA_STATUS_W  = 3;
    localparam int FBPA_CFG_IDX_W = 2;

    // Largest pool size in blocks; larger max_units values clamp here
    localparam int FBPA_MAX_UNITS = 65536;

    // Default free stack depth
    localparam int FBPA_STACK_DEPTH = 64;

    // Remainder unit: one dividend bit per cycle
    localparam int FBPA_DIV_STEPS = FBPA_ADDR_W;
    localparam int FBPA_DCNT_W    = $clog2(FBPA_DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic [FBPA_CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [FBPA_CFG_IDX_W-1:0] REG_UNIT_SIZE    = 2'd1;
    localparam logic [FBPA_CFG_IDX_W-1:0] REG_MAX_UNITS    = 2'd2;

    // Input commands
    typedef enum logic [FBPA_CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RESET = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [FBPA_STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EXHAUSTED   = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_MISALIGNED  = 3'd3,
        ST_DOUBLE_FREE = 3'd4,
        ST_STACK_FULL  = 3'd5
    } status_t;

    // State update applied when an item finishes
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_ALLOC_BUMP = 3'd1,
        OP_ALLOC_POP  = 3'd2,
        OP_PUSH       = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    accept;
        logic    rd_pop;
        logic    div_start;
        logic    div_step;
        logic    search_start;
        logic    search_step;
        logic    fin;
        op_t     op;
        status_t code;
        logic    out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [FBPA_CMD_W-1:0] cmd;
        logic pool_full;
        logic stack_empty;
        logic stack_full;
        logic out_of_range;
        logic div_done;
        logic misaligned;
        logic search_hit;
        logic search_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- design/fbpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the free stack; no dependencies.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/fbpa_ctrl.sv -----
// Sequencing state machine for the fixed block pool allocator.
// Depends on fbpa_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps

module fbpa_ctrl import fbpa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t st,
    output dp_cmd_t  ctl
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_POP    = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_SEARCH = 7'b0010000,
        S_RESULT = 7'b0100000,
        S_SPARE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.op     = OP_NONE;
        ctl.code   = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (st.cmd)
                    CMD_ALLOC: begin
                        if (st.pool_full) begin
                            ctl.fin    = 1'b1;
                            ctl.code   = ST_EXHAUSTED;
                            state_next = S_RESULT;
                        end else if (!st.stack_empty) begin
                            ctl.rd_pop = 1'b1;
                            state_next = S_POP;
                        end else begin
                            ctl.fin    = 1'b1;
                            ctl.op     = OP_ALLOC_BUMP;
                            state_next = S_RESULT;
                        end
                    end
                    CMD_FREE: begin
                        if (st.out_of_range) begin
                            ctl.fin    = 1'b1;
                            ctl.code   = ST_OUT_OF_RANGE;
                            state_next = S_RESULT;
                        end else begin
                            ctl.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    CMD_RESET: begin
                        ctl.fin    = 1'b1;
                        ctl.op     = OP_CLEAR;
                        state_next = S_RESULT;
                    end
                    default: begin
                        ctl.fin    = 1'b1;
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_POP: begin
                // Popped entry is on the RAM read port now
                ctl.fin    = 1'b1;
                ctl.op     = OP_ALLOC_POP;
                state_next = S_RESULT;
            end
            S_DIV: begin
                if (!st.div_done) begin
                    ctl.div_step = 1'b1;
                end else if (st.misaligned) begin
                    ctl.fin    = 1'b1;
                    ctl.code   = ST_MISALIGNED;
                    state_next = S_RESULT;
                end else begin
                    ctl.search_start = 1'b1;
                    state_next       = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (st.search_hit) begin
                    ctl.fin    = 1'b1;
                    ctl.code   = ST_DOUBLE_FREE;
                    state_next = S_RESULT;
                end else if (st.search_busy) begin
                    ctl.search_step = 1'b1;
                end else if (st.stack_full) begin
                    ctl.fin    = 1'b1;
                    ctl.code   = ST_STACK_FULL;
                    state_next = S_RESULT;
                end else begin
                    ctl.fin    = 1'b1;
                    ctl.op     = OP_PUSH;
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                // Hand the result to the output register once it is free
                if (st.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/fbpa_dp.sv -----
// Datapath of the fixed block pool allocator: configuration, counters, range
// multiplier, remainder unit, free stack RAM and output register.
// Depends on fbpa_pkg and fbpa_ram; commanded by fbpa_ctrl.
`timescale 1ns / 1ps

module fbpa_dp import fbpa_pkg::*; #(
    parameter  int FREE_STACK_DEPTH = FBPA_STACK_DEPTH,
    localparam int FILL_W = $clog2(FREE_STACK_DEPTH + 1),
    localparam int RAM_AW = (FREE_STACK_DEPTH > 1) ? $clog2(FREE_STACK_DEPTH) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_cmd_t                   ctl,
    output dp_stat_t                  st,
    input  logic [FBPA_CMD_W-1:0]     s_cmd,
    input  logic [FBPA_ADDR_W-1:0]    s_address,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [FBPA_CFG_IDX_W-1:0] cfg_index,
    input  logic [FBPA_ADDR_W-1:0]    cfg_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [FBPA_ADDR_W-1:0]    m_block_address,
    output logic [FBPA_STATUS_W-1:0]  m_status,
    output logic [FBPA_COUNT_W-1:0]   m_used_count,
    output logic [FILL_W-1:0]         m_free_count,
    output logic                      m_pool_full,
    output logic [FBPA_COUNT_W-1:0]   m_peak_used,
    output logic [FILL_W-1:0]         m_peak_free
);

    localparam int SPAN_W = FBPA_COUNT_W + FBPA_UNIT_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(FREE_STACK_DEPTH);

    // Configuration
    logic [FBPA_ADDR_W-1:0]  base_reg;
    logic [FBPA_UNIT_W-1:0]  unit_reg;
    logic [FBPA_COUNT_W-1:0] max_reg;
    logic [FBPA_UNIT_W-1:0]  eff_unit;
    logic [FBPA_COUNT_W-1:0] eff_max;

    // Captured item and range check
    logic [FBPA_CMD_W-1:0]   cmd_reg;
    logic [FBPA_ADDR_W-1:0]  addr_reg;
    logic [FBPA_ADDR_W-1:0]  off_reg;
    logic                    below_reg;
    logic [SPAN_W-1:0]       span_reg;

    // Pool state
    logic [FBPA_COUNT_W-1:0] used_reg, used_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [FBPA_ADDR_W-1:0]  bump_reg, bump_next;
    logic [FBPA_COUNT_W-1:0] peak_used_reg, peak_used_next;
    logic [FILL_W-1:0]       peak_free_reg, peak_free_next;
    logic [FILL_W-1:0]       fill_dec;
    logic                    pool_full;

    // Remainder unit
    logic [FBPA_UNIT_W-1:0]  rem_reg, rem_next;
    logic [FBPA_ADDR_W-1:0]  dvd_reg;
    logic [FBPA_DCNT_W-1:0]  dcnt_reg;
    logic [FBPA_UNIT_W:0]    rem_trial;
    logic [FBPA_UNIT_W:0]    rem_sub;

    // Double free search
    logic [FILL_W-1:0]       idx_reg;
    logic                    cmp_valid_reg;
    logic                    search_more;

    // Free stack RAM
    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [RAM_AW-1:0]       ram_rd_addr;
    logic [FBPA_ADDR_W-1:0]  ram_rd_data;

    // Finished result awaiting the output register
    logic [FBPA_STATUS_W-1:0] res_status_reg;
    logic [FBPA_ADDR_W-1:0]   res_block_reg, res_block_next;

    // Output register
    logic                     m_valid_reg;
    logic [FBPA_ADDR_W-1:0]   m_block_reg;
    logic [FBPA_STATUS_W-1:0] m_status_reg;
    logic [FBPA_COUNT_W-1:0]  m_used_reg;
    logic [FILL_W-1:0]        m_free_reg;
    logic                     m_full_reg;
    logic [FBPA_COUNT_W-1:0]  m_peak_used_reg;
    logic [FILL_W-1:0]        m_peak_free_reg;

    // Clamp the configuration to its usable range
    assign eff_unit  = (unit_reg == '0) ? FBPA_UNIT_W'(1) : unit_reg;
    assign eff_max   = (max_reg > FBPA_COUNT_W'(FBPA_MAX_UNITS)) ?
                       FBPA_COUNT_W'(FBPA_MAX_UNITS) : max_reg;
    assign pool_full = (used_reg >= eff_max);
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            unit_reg <= FBPA_UNIT_W'(1);
            max_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_reg <= cfg_data;
                REG_UNIT_SIZE:    unit_reg <= cfg_data[FBPA_UNIT_W-1:0];
                REG_MAX_UNITS:    max_reg  <= cfg_data[FBPA_COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture the item, its offset into the region and the region span
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg   <= s_cmd;
            addr_reg  <= s_address;
            off_reg   <= s_address - base_reg;
            below_reg <= (s_address < base_reg);
            span_reg  <= SPAN_W'(eff_max) * SPAN_W'(eff_unit);
        end
    end

    // Remainder of the offset by the block size, one dividend bit per cycle
    assign rem_trial = {rem_reg, dvd_reg[FBPA_ADDR_W-1]};
    assign rem_sub   = rem_trial - {1'b0, eff_unit};
    assign rem_next  = (rem_trial >= {1'b0, eff_unit}) ?
                       rem_sub[FBPA_UNIT_W-1:0] : rem_trial[FBPA_UNIT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (ctl.div_start) begin
            dcnt_reg <= FBPA_DCNT_W'(FBPA_DIV_STEPS);
        end else if (ctl.div_step) begin
            dcnt_reg <= dcnt_reg - FBPA_DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.div_start) begin
            rem_reg <= '0;
            dvd_reg <= off_reg;
        end else if (ctl.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[FBPA_ADDR_W-2:0], 1'b0};
        end
    end

    // Walk the stack one entry a cycle; compare each entry on the registered RAM read data
    assign search_more = (idx_reg < fill_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else if (ctl.search_start) begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else if (ctl.search_step) begin
            cmp_valid_reg <= search_more;
            if (search_more) begin
                idx_reg <= idx_reg + FILL_W'(1);
            end
        end
    end

    // Free stack RAM: push at the fill level, pop just below it
    assign fill_dec    = fill_reg - FILL_W'(1);
    assign ram_wr_en   = ctl.fin && (ctl.op == OP_PUSH);
    assign ram_rd_en   = ctl.rd_pop || (ctl.search_step && search_more);
    assign ram_rd_addr = ctl.rd_pop ? fill_dec[RAM_AW-1:0] : idx_reg[RAM_AW-1:0];

    fbpa_ram #(
        .WIDTH (FBPA_ADDR_W),
        .DEPTH (FREE_STACK_DEPTH)
    ) u_free_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_reg[RAM_AW-1:0]),
        .wr_data (addr_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Pool state update for the finishing item
    always_comb begin
        used_next      = used_reg;
        fill_next      = fill_reg;
        bump_next      = bump_reg;
        res_block_next = '0;
        case (ctl.op)
            OP_ALLOC_BUMP: begin
                used_next      = used_reg + FBPA_COUNT_W'(1);
                res_block_next = base_reg + bump_reg;
                bump_next      = bump_reg + FBPA_ADDR_W'(eff_unit);
            end
            OP_ALLOC_POP: begin
                used_next      = used_reg + FBPA_COUNT_W'(1);
                fill_next      = fill_dec;
                res_block_next = ram_rd_data;
            end
            OP_PUSH: begin
                fill_next = fill_reg + FILL_W'(1);
                if (used_reg != '0) begin
                    used_next = used_reg - FBPA_COUNT_W'(1);
                end
            end
            OP_CLEAR: begin
                used_next = '0;
                fill_next = '0;
                bump_next = '0;
            end
            default: ;
        endcase
        peak_used_next = (used_next > peak_used_reg) ? used_next : peak_used_reg;
        peak_free_next = (fill_next > peak_free_reg) ? fill_next : peak_free_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            fill_reg      <= '0;
            bump_reg      <= '0;
            peak_used_reg <= '0;
            peak_free_reg <= '0;
        end else if (ctl.fin) begin
            used_reg      <= used_next;
            fill_reg      <= fill_next;
            bump_reg      <= bump_next;
            peak_used_reg <= peak_used_next;
            peak_free_reg <= peak_free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fin) begin
            res_status_reg <= ctl.code;
            res_block_reg  <= res_block_next;
        end
    end

    // Output register; counts are sampled after the update has landed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_block_reg     <= res_block_reg;
            m_status_reg    <= res_status_reg;
            m_used_reg      <= used_reg;
            m_free_reg      <= fill_reg;
            m_full_reg      <= pool_full;
            m_peak_used_reg <= peak_used_reg;
            m_peak_free_reg <= peak_free_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_block_address = m_block_reg;
    assign m_status        = m_status_reg;
    assign m_used_count    = m_used_reg;
    assign m_free_count    = m_free_reg;
    assign m_pool_full     = m_full_reg;
    assign m_peak_used     = m_peak_used_reg;
    assign m_peak_free     = m_peak_free_reg;

    // Status back to the controller
    always_comb begin
        st              = '0;
        st.cmd          = cmd_reg;
        st.pool_full    = pool_full;
        st.stack_empty  = (fill_reg == '0);
        st.stack_full   = (fill_reg == FILL_MAX);
        st.out_of_range = below_reg || ({1'b0, off_reg} >= span_reg);
        st.div_done     = (dcnt_reg == '0);
        st.misaligned   = (rem_reg != '0);
        st.search_hit   = cmp_valid_reg && (ram_rd_data == addr_reg);
        st.search_busy  = search_more || cmp_valid_reg;
        st.out_free     = !m_valid_reg || m_ready;
    end

    // Never push onto a full stack
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.fin && ctl.op == OP_PUSH) |-> (fill_reg != FILL_MAX))
        else $error("push issued with the free stack full");

    // Never pop an empty stack
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.rd_pop |-> (fill_reg != '0))
        else $error("pop issued with the free stack empty");

    // A bump allocation raises the used count by exactly one
    a_bump_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.fin && ctl.op == OP_ALLOC_BUMP) |=>
        (used_reg == $past(used_reg) + FBPA_COUNT_W'(1)))
        else $error("used count did not advance on allocate");

    // Peaks track the live counts
    a_peaks: assert property (@(posedge aclk) disable iff (!aresetn)
        (peak_used_reg >= used_reg) && (peak_free_reg >= fill_reg))
        else $error("peak statistic below the live count");

endmodule

// ----- design/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator. Each item is one command: allocate, free an
// address, or reset the pool; each item gives exactly one result. An allocate
// takes its block from the bump pointer, or pops the free stack when it holds an
// entry, and the pop waits on the registered RAM read. Pool reset, an exhausted
// allocate, an out-of-range free and the unused command finish straight from
// decode. A free inside the region runs the bit-serial alignment remainder first.
// An aligned free then searches the free stack for a double free over the single
// read port of the free stack RAM, one entry a cycle, and stops early when a
// double free hits. A finished result waits for the output register to free up.
// The next item is accepted while a finished result still waits in the output
// register. Configuration writes are taken at any time but must only be issued
// while the block is idle. The free stack RAM needs no clearing after reset.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp and fbpa_ram.
`timescale 1ns / 1ps

module fixed_block_pool_allocator import fbpa_pkg::*; #(
    parameter  int FREE_STACK_DEPTH = FBPA_STACK_DEPTH,
    localparam int FILL_W = $clog2(FREE_STACK_DEPTH + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Command input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FBPA_CMD_W-1:0]     s_cmd,
    input  logic [FBPA_ADDR_W-1:0]    s_address,
    // Result output
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [FBPA_ADDR_W-1:0]    m_block_address,
    output logic [FBPA_STATUS_W-1:0]  m_status,
    output logic [FBPA_COUNT_W-1:0]   m_used_count,
    output logic [FILL_W-1:0]         m_free_count,
    output logic                      m_pool_full,
    output logic [FBPA_COUNT_W-1:0]   m_peak_used,
    output logic [FILL_W-1:0]         m_peak_free,
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [FBPA_CFG_IDX_W-1:0] cfg_index,
    input  logic [FBPA_ADDR_W-1:0]    cfg_data
);

    dp_cmd_t  ctl;
    dp_stat_t st;

    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctl     (ctl)
    );

    fbpa_dp #(
        .FREE_STACK_DEPTH (FREE_STACK_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (ctl),
        .st              (st),
        .s_cmd           (s_cmd),
        .s_address       (s_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_block_address (m_block_address),
        .m_status        (m_status),
        .m_used_count    (m_used_count),
        .m_free_count    (m_free_count),
        .m_pool_full     (m_pool_full),
        .m_peak_used     (m_peak_used),
        .m_peak_free     (m_peak_free)
    );

endmodule

// ----- dv/fixed_block_pool_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for fixed_block_pool_allocator: directed and random command items,
// each result compared with an in-bench model of the pool and its free stack.
// Depends on fbpa_pkg and the allocator RTL.

module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int STACK_DEPTH     = FBPA_STACK_DEPTH;
    localparam int FILL_W          = $clog2(STACK_DEPTH + 1);
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ROUNDS   = 8;
    localparam int ITEMS_PER_ROUND = 60;

    // Command code the block leaves undecoded
    localparam logic [FBPA_CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [FBPA_ADDR_W-1:0]  block_address;
        status_t                 status;
        logic [FBPA_COUNT_W-1:0] used_count;
        logic [FILL_W-1:0]       free_count;
        logic                    pool_full;
        logic [FBPA_COUNT_W-1:0] peak_used;
        logic [FILL_W-1:0]       peak_free;
    } pool_result_t;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [FBPA_CMD_W-1:0]     s_cmd     = '0;
    logic [FBPA_ADDR_W-1:0]    s_address = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic [FBPA_ADDR_W-1:0]    m_block_address;
    logic [FBPA_STATUS_W-1:0]  m_status;
    logic [FBPA_COUNT_W-1:0]   m_used_count;
    logic [FILL_W-1:0]         m_free_count;
    logic                      m_pool_full;
    logic [FBPA_COUNT_W-1:0]   m_peak_used;
    logic [FILL_W-1:0]         m_peak_free;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [FBPA_CFG_IDX_W-1:0] cfg_index = '0;
    logic [FBPA_ADDR_W-1:0]    cfg_data  = '0;

    // Pool model: configuration and state as seen after each accepted item
    logic [FBPA_ADDR_W-1:0]    cfg_base  = '0;
    logic [FBPA_UNIT_W-1:0]    cfg_unit  = 16'd1;
    logic [FBPA_COUNT_W-1:0]   cfg_max   = '0;
    logic [FBPA_COUNT_W-1:0]   model_used = '0;
    int                        model_fill = 0;
    logic [FBPA_ADDR_W-1:0]    model_bump = '0;
    logic [FBPA_ADDR_W-1:0]    model_stack [STACK_DEPTH];
    logic [FBPA_COUNT_W-1:0]   model_peak_used = '0;
    logic [FILL_W-1:0]         model_peak_free = '0;

    pool_result_t              pending_results [$];
    logic [FBPA_ADDR_W-1:0]    live_blocks [$];
    int                        mismatches     = 0;
    int                        send_idle_pct  = 0;
    int                        recv_stall_pct = 0;

    fixed_block_pool_allocator #(
        .FREE_STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_address       (s_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_block_address (m_block_address),
        .m_status        (m_status),
        .m_used_count    (m_used_count),
        .m_free_count    (m_free_count),
        .m_pool_full     (m_pool_full),
        .m_peak_used     (m_peak_used),
        .m_peak_free     (m_peak_free),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("fixed_block_pool_allocator_test: FAIL");
        $finish;
    end

    // Block size in bytes; zero counts as one
    function automatic logic [FBPA_ADDR_W-1:0] unit_bytes();
        return (cfg_unit == '0) ? 32'd1 : 32'(cfg_unit);
    endfunction

    // Pool size in blocks, clamped to the largest pool
    function automatic logic [FBPA_COUNT_W-1:0] pool_limit();
        return (cfg_max > 17'd65536) ? 17'd65536 : cfg_max;
    endfunction

    // Apply one command to the pool model and return the result it gives
    function automatic pool_result_t predict_pool_step(input logic [FBPA_CMD_W-1:0] cmd,
                                                       input logic [FBPA_ADDR_W-1:0] addr);
        pool_result_t            r;
        logic [FBPA_ADDR_W-1:0]  unit;
        logic [FBPA_COUNT_W-1:0] limit;
        logic [63:0]             span;
        logic [FBPA_ADDR_W-1:0]  off;
        bit                      dup;
        unit = unit_bytes();
        limit = pool_limit();
        dup = 1'b0;
        r.block_address = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ALLOC: begin
                if (model_used >= limit) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    model_used = model_used + 1'b1;
                    if (model_peak_used < model_used) model_peak_used = model_used;
                    // Pop the most recently freed block, else take the bump pointer
                    if (model_fill > 0) begin
                        model_fill--;
                        r.block_address = model_stack[model_fill];
                    end else begin
                        r.block_address = cfg_base + model_bump;
                        model_bump = model_bump + unit;
                    end
                end
            end
            CMD_FREE: begin
                // Region check without wrap: the end bound is outside
                span = 64'(limit) * 64'(unit);
                off = addr - cfg_base;
                if (addr < cfg_base || 64'(off) >= span) begin
                    r.status = ST_OUT_OF_RANGE;
                end else if (off % unit != 0) begin
                    r.status = ST_MISALIGNED;
                end else begin
                    for (int i = 0; i < model_fill; i++) begin
                        if (model_stack[i] == addr) dup = 1'b1;
                    end
                    if (dup) begin
                        r.status = ST_DOUBLE_FREE;
                    end else if (model_fill >= STACK_DEPTH) begin
                        r.status = ST_STACK_FULL;
                    end else begin
                        model_stack[model_fill] = addr;
                        model_fill++;
                        if (model_used != '0) model_used = model_used - 1'b1;
                        if (model_peak_free < model_fill) model_peak_free = FILL_W'(model_fill);
                    end
                end
            end
            CMD_RESET: begin
                model_used = '0;
                model_fill = 0;
                model_bump = '0;
            end
            default: ;
        endcase
        r.used_count = model_used;
        r.free_count = FILL_W'(model_fill);
        r.pool_full  = (model_used >= limit);
        r.peak_used  = model_peak_used;
        r.peak_free  = model_peak_free;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    function automatic void set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endfunction

    // Drive result ready at random and compare each accepted result with the oldest one due
    always @(posedge aclk) begin : result_check
        pool_result_t want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, block_address 0x%0h status %0d",
                         $time, m_block_address, m_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("block_address", want.block_address, m_block_address);
                check_field("status", want.status, m_status);
                check_field("used_count", want.used_count, m_used_count);
                check_field("free_count", want.free_count, m_free_count);
                check_field("pool_full", want.pool_full, m_pool_full);
                check_field("peak_used", want.peak_used, m_peak_used);
                check_field("peak_free", want.peak_free, m_peak_free);
            end
        end
    end

    // Send one command item, then predict its result and track the live blocks
    task automatic send_item(input logic [FBPA_CMD_W-1:0] cmd,
                             input logic [FBPA_ADDR_W-1:0] addr);
        pool_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        r = predict_pool_step(cmd, addr);
        pending_results.push_back(r);
        if (cmd == CMD_ALLOC && r.status == ST_OK) begin
            live_blocks.push_back(r.block_address);
        end else if (cmd == CMD_FREE && r.status == ST_OK) begin
            foreach (live_blocks[i]) begin
                if (live_blocks[i] == addr) begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end else if (cmd == CMD_RESET) begin
            live_blocks.delete();
        end
    endtask

    // Drop valid, wait for every result, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [FBPA_CFG_IDX_W-1:0] idx,
                             input logic [FBPA_ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BASE_ADDRESS: cfg_base = data;
            REG_UNIT_SIZE:    cfg_unit = data[FBPA_UNIT_W-1:0];
            REG_MAX_UNITS:    cfg_max  = data[FBPA_COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Write all three registers back to back; call only when settled
    task automatic set_pool(input logic [FBPA_ADDR_W-1:0] base,
                            input logic [FBPA_UNIT_W-1:0] unit,
                            input logic [FBPA_COUNT_W-1:0] limit);
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_UNIT_SIZE, 32'(unit));
        write_reg(REG_MAX_UNITS, 32'(limit));
        cfg_valid <= 1'b0;
    endtask

    // Reset configuration: an empty pool, so allocate is exhausted and every free out of range
    task automatic test_power_up_config();
        send_item(CMD_ALLOC, 32'hFFFF_FFFF);
        send_item(CMD_FREE, 32'h0000_0000);
    endtask

    // Small pool: bump, exhaustion, double, misaligned and out-of-range frees, pop, unused command, pool reset
    task automatic test_basic_pool();
        settle();
        set_pool(32'h0000_1000, 16'd16, 17'd4);
        repeat (4) send_item(CMD_ALLOC, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, 32'h0000_1010);
        send_item(CMD_FREE, 32'h0000_1010);
        send_item(CMD_FREE, 32'h0000_1008);
        send_item(CMD_FREE, 32'h0000_0FFF);
        send_item(CMD_FREE, 32'h0000_1040);
        send_item(CMD_FREE, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF);
        send_item(CMD_RESET, '0);
        // Never allocated since the pool reset: accept it, hold used count at zero
        send_item(CMD_FREE, 32'h0000_1020);
    endtask

    // Zero unit size with a wrapping handed-out address, then an oversized max_units
    task automatic test_size_extremes();
        settle();
        set_pool(32'hFFFF_FFFE, 16'd0, 17'd3);
        repeat (3) send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, 32'h0000_0000);
        settle();
        set_pool(32'h0000_0000, 16'hFFFF, 17'h1FFFF);
        send_item(CMD_RESET, '0);
        send_item(CMD_ALLOC, '0);
        send_item(CMD_FREE, 32'hFFFF_FFFF);
    endtask

    // Fill the free stack past its depth, hit a double free while full, then drain it
    task automatic test_stack_overflow();
        settle();
        set_idling(0, 54);
        set_pool($urandom & 32'h7FFF_FFFC, 16'd4, 17'd80);
        send_item(CMD_RESET, $urandom);
        repeat (STACK_DEPTH + 6) send_item(CMD_ALLOC, $urandom);
        repeat (STACK_DEPTH + 2) begin
            send_item(CMD_FREE, live_blocks[$urandom_range(live_blocks.size() - 1)]);
        end
        send_item(CMD_FREE, model_stack[$urandom_range(model_fill - 1)]);
        repeat (STACK_DEPTH + 2) send_item(CMD_ALLOC, $urandom);
    endtask

    // Mostly alloc and free of live blocks; the rest double, bogus, misaligned and stray frees, resets, unused commands
    task automatic run_random_round(input int items);
        logic [FBPA_ADDR_W-1:0]  unit;
        logic [FBPA_COUNT_W-1:0] limit;
        int                      pick;
        for (int n = 0; n < items; n++) begin
            unit = unit_bytes();
            limit = pool_limit();
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_item(CMD_ALLOC, $urandom);
            end else if (pick < 70 && live_blocks.size() > 0) begin
                send_item(CMD_FREE, live_blocks[$urandom_range(live_blocks.size() - 1)]);
            end else if (pick < 76 && model_fill > 0) begin
                send_item(CMD_FREE, model_stack[$urandom_range(model_fill - 1)]);
            end else if (pick < 84 && limit != '0) begin
                send_item(CMD_FREE, cfg_base + unit * $urandom_range(32'(limit) - 1));
            end else if (pick < 90) begin
                send_item(CMD_FREE, cfg_base + unit * $urandom_range(32'(limit))
                                    + $urandom_range(unit));
            end else if (pick < 93) begin
                send_item(CMD_FREE, cfg_base + 32'(limit) * unit);
            end else if (pick < 96) begin
                send_item(CMD_FREE, $urandom);
            end else if (pick < 98) begin
                send_item(CMD_RESET, $urandom);
            end else begin
                send_item(CMD_UNUSED, $urandom);
            end
        end
    endtask

    // Random traffic over a range of pool shapes and idling profiles
    task automatic test_random_pools();
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            settle();
            case (round % 4)
                0: set_idling(0, 0);
                1: set_idling(54, 0);
                2: set_idling(0, 54);
                default: set_idling(13, 13);
            endcase
            case (round)
                0: set_pool($urandom, 16'($urandom_range(16, 1)), 17'($urandom_range(12, 1)));
                1: set_pool(32'hFFFF_FFFF - $urandom_range(64), 16'($urandom_range(8, 1)),
                            17'd16);
                2: set_pool(32'h0000_0000, 16'd0, 17'd20);
                3: set_pool($urandom, 16'hFFFF, 17'h1FFFF);
                4: set_pool(32'hFFFF_FFFF, 16'd1, 17'd65536);
                5: set_pool($urandom, 16'($urandom), 17'($urandom_range(100, 1)));
                6: set_pool($urandom, 16'($urandom), 17'd0);
                default: set_pool($urandom & 32'hFFFF_F000, 16'($urandom_range(4, 1)), 17'd70);
            endcase
            if ($urandom_range(1) == 1) send_item(CMD_RESET, $urandom);
            run_random_round(ITEMS_PER_ROUND);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(13, 13);
        test_power_up_config();
        test_basic_pool();
        test_size_extremes();
        test_stack_overflow();
        test_random_pools();
        settle();
        if (mismatches == 0) begin
            $display("fixed_block_pool_allocator_test: PASS");
        end else begin
            $display("fixed_block_pool_allocator_test: FAIL");
        end
        $finish;
    end

endmodule
